>>> sv/edit_distance_engine_macros.svh
// ----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ede_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Sizes, item types, action codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ede_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SYMBOL_BITS = 8;

  localparam int ACTION_W    = 2;
  localparam int SYMBOL_IN_W = 8;
  localparam int DIST_W      = 7;
  localparam int DIST_MAX    = 127;

  // Stored symbol width: the input field limits what can be kept.
  localparam int SYM_W   = (SYMBOL_BITS < SYMBOL_IN_W) ? SYMBOL_BITS : SYMBOL_IN_W;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COST_W  = $clog2(MAX_LEN + 1);
  localparam int ROW_LEN = MAX_LEN + 1;

  localparam logic [ACTION_W-1:0] ACT_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [SYMBOL_IN_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_CELL,
    ST_DONE
  } state_t;

endpackage

>>> sv/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two stored symbol strings, one cost row in RAM.
// ----------------------------------------------------------------------------
//  Channel  Handshake                    Payload
//  -------  ---------------------------  ----------------------------------
//  item     item_valid / item_ready      item.action, item.symbol
//  result   result_valid / result_ready  result.distance, result.overflow
//
//  A run computes one cell per cycle through the shared compare/minimum unit,
//  set by the single read port of the cost row RAM. item_ready is low during
//  a run and while a finished result waits for a free output register. Loads
//  are taken while an earlier result is still pending.
//  Reset (rst, synchronous) clears the lengths, the overflow flag and the
//  sequencer; the symbol and cost memories need no clearing.
`timescale 1ns / 1ps

`include "edit_distance_engine_macros.svh"

module edit_distance_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ede_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output ede_pkg::result_t result
);

  import ede_pkg::*;

  state_t state, state_next;

  logic [SYM_W-1:0]  first_mem  [MAX_LEN];
  logic [SYM_W-1:0]  second_mem [MAX_LEN];
  logic [COST_W-1:0] cost_mem   [ROW_LEN];

  logic [LEN_W-1:0]  first_length, second_length;
  logic              overflow_seen;
  logic [LEN_W-1:0]  i, j;
  logic [LEN_W-1:0]  i_prev;
  logic [COST_W-1:0] diag, left;
  logic [SYM_W-1:0]  a_sym;

  logic [SYM_W-1:0]  fs_rd, ss_rd;
  logic [COST_W-1:0] cost_rd;
  logic [IDX_W-1:0]  fs_raddr, ss_raddr;
  logic [LEN_W-1:0]  cr_raddr, cr_waddr;
  logic [COST_W-1:0] cr_wdata;
  logic              cr_we;

  logic              item_xfer, load_first, load_second, start_run;
  logic              row_end, last_row, result_load;
  logic [COST_W:0]   up_inc, left_inc, sub_cost, min_ul, min_all;
  logic [COST_W-1:0] cell_cost, dist_full;

  assign item_ready  = (state == ST_IDLE);
  assign item_xfer   = item_valid && item_ready;
  assign load_first  = item_xfer && (item.action == ACT_FIRST);
  assign load_second = item_xfer && (item.action == ACT_SECOND);
  assign start_run   = item_xfer && (item.action == ACT_RUN);

  assign i_prev   = i - LEN_W'(1);
  assign row_end  = (j == second_length);
  assign last_row = (i == first_length);
  assign result_load = (state == ST_DONE) && (!result_valid || result_ready);

  // Shared cell unit: minimum of insert, delete and substitute costs.
  assign up_inc   = {1'b0, cost_rd} + (COST_W + 1)'(1);
  assign left_inc = {1'b0, left} + (COST_W + 1)'(1);
  assign sub_cost = {1'b0, diag} + (COST_W + 1)'(a_sym != ss_rd);
  assign min_ul   = (up_inc < left_inc) ? up_inc : left_inc;
  assign min_all  = (min_ul < sub_cost) ? min_ul : sub_cost;
  assign cell_cost = min_all[COST_W-1:0];

  // With an empty first string the answer is the second length; otherwise it
  // is the last cost computed in the final row.
  assign dist_full = (first_length == '0) ? COST_W'(second_length) : left;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_run) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (row_end) state_next = (first_length == '0) ? ST_DONE : ST_ROW_RD;
      end
      ST_ROW_RD: state_next = ST_ROW_WR;
      ST_ROW_WR: begin
        if (second_length != '0) state_next = ST_CELL;
        else state_next = last_row ? ST_DONE : ST_ROW_RD;
      end
      ST_CELL: begin
        if (row_end) state_next = last_row ? ST_DONE : ST_ROW_RD;
      end
      ST_DONE: begin
        if (result_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cr_we    = 1'b0;
    cr_waddr = j;
    cr_wdata = cell_cost;
    cr_raddr = '0;
    fs_raddr = i_prev[IDX_W-1:0];
    ss_raddr = '0;
    unique case (state)
      ST_INIT: begin
        cr_we    = 1'b1;
        cr_wdata = COST_W'(j);
      end
      ST_ROW_WR: begin
        cr_we    = 1'b1;
        cr_waddr = '0;
        cr_wdata = COST_W'(i);
        cr_raddr = LEN_W'(1);
      end
      ST_CELL: begin
        cr_we    = 1'b1;
        cr_raddr = j + LEN_W'(1);
        ss_raddr = j[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_first && (first_length < LEN_W'(MAX_LEN))) begin
      first_mem[first_length[IDX_W-1:0]] <= item.symbol[SYM_W-1:0];
    end
    if (load_second && (second_length < LEN_W'(MAX_LEN))) begin
      second_mem[second_length[IDX_W-1:0]] <= item.symbol[SYM_W-1:0];
    end
    if (cr_we) begin
      cost_mem[cr_waddr] <= cr_wdata;
    end
    fs_rd   <= first_mem[fs_raddr];
    ss_rd   <= second_mem[ss_raddr];
    cost_rd <= cost_mem[cr_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_first) begin
        if (first_length < LEN_W'(MAX_LEN)) first_length <= first_length + LEN_W'(1);
        else overflow_seen <= 1'b1;
      end
      if (load_second) begin
        if (second_length < LEN_W'(MAX_LEN)) second_length <= second_length + LEN_W'(1);
        else overflow_seen <= 1'b1;
      end
      if (result_load) begin
        result_valid  <= 1'b1;
        first_length  <= '0;
        second_length <= '0;
        overflow_seen <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        j <= '0;
        i <= LEN_W'(1);
      end
      ST_INIT: begin
        if (!row_end) j <= j + LEN_W'(1);
      end
      ST_ROW_WR: begin
        diag  <= cost_rd;
        a_sym <= fs_rd;
        left  <= COST_W'(i);
        j     <= LEN_W'(1);
        if ((second_length == '0) && !last_row) i <= i + LEN_W'(1);
      end
      ST_CELL: begin
        left <= cell_cost;
        diag <= cost_rd;
        if (!row_end) j <= j + LEN_W'(1);
        else if (!last_row) i <= i + LEN_W'(1);
      end
      default: ;
    endcase
    if (result_load) begin
      result.distance <= (32'(dist_full) > 32'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                          : DIST_W'(dist_full);
      result.overflow <= overflow_seen;
    end
  end

  `EDE_ASSERT_NOW(a_len_bound, 1'b1,
    (first_length <= LEN_W'(MAX_LEN)) && (second_length <= LEN_W'(MAX_LEN)),
    "stored string length beyond capacity")
  `EDE_ASSERT_NOW(a_cell_range, state == ST_CELL,
    (j != '0) && (j <= second_length) && (i != '0) && (i <= first_length),
    "cell index outside the dynamic program")
  `EDE_ASSERT_NEXT(a_run_start, start_run, state == ST_INIT,
    "run transfer did not start the sequencer")
  `EDE_ASSERT_NEXT(a_result_clear, result_load,
    result_valid && (first_length == '0) && (second_length == '0) && !overflow_seen,
    "result not presented or string state not cleared")

endmodule

>>> tb/edit_distance_checker.sv
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Watches both channels of the engine, keeps its own copy of the two strings
// and predicts the distance and overflow flag of every run transfer. Each
// result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edit_distance_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  ede_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  ede_pkg::result_t result,
  output int               fail_count,
  output int               pending,
  output int               load_count,
  output int               run_count,
  output int               overflow_count,
  output int               longest
);

  import ede_pkg::*;

  logic [SYM_W-1:0] first_syms [MAX_LEN];
  logic [SYM_W-1:0] second_syms [MAX_LEN];
  int               first_len;
  int               second_len;
  bit               truncated;
  result_t          expected_results [$];

  int fails;
  int loads;
  int runs;
  int truncations;
  int widest;

  // One row of the unit-cost table is enough: each cell needs only the cell
  // above it, the cell to its left and the old upper-left neighbor.
  function automatic result_t edit_distance();
    int      row [MAX_LEN + 1];
    int      diag;
    int      above;
    int      sub_cost;
    int      best;
    result_t res;
    for (int j = 0; j <= second_len; j++) row[j] = j;
    for (int i = 1; i <= first_len; i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        above = row[j];
        sub_cost = diag + ((first_syms[i-1] == second_syms[j-1]) ? 0 : 1);
        best = (above + 1 < row[j-1] + 1) ? above + 1 : row[j-1] + 1;
        row[j] = (sub_cost < best) ? sub_cost : best;
        diag = above;
      end
    end
    best = (row[second_len] > DIST_MAX) ? DIST_MAX : row[second_len];
    res.distance = best[DIST_W-1:0];
    res.overflow = truncated;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      first_len = 0;
      second_len = 0;
      truncated = 1'b0;
      expected_results.delete();
      fails = 0;
      loads = 0;
      runs = 0;
      truncations = 0;
      widest = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no run pending: distance %0d overflow %0b",
                 result.distance, result.overflow);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (result.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, result.distance);
            fails++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, result.overflow);
            fails++;
          end
        end
      end
      if (item_valid && item_ready) begin
        case (item.action)
          ACT_FIRST: begin
            loads++;
            if (first_len < MAX_LEN) begin
              first_syms[first_len] = item.symbol[SYM_W-1:0];
              first_len++;
            end else begin
              truncated = 1'b1;
            end
          end
          ACT_SECOND: begin
            loads++;
            if (second_len < MAX_LEN) begin
              second_syms[second_len] = item.symbol[SYM_W-1:0];
              second_len++;
            end else begin
              truncated = 1'b1;
            end
          end
          ACT_RUN: begin
            runs++;
            if (truncated) truncations++;
            if (first_len > widest) widest = first_len;
            if (second_len > widest) widest = second_len;
            expected_results.push_back(edit_distance());
            first_len = 0;
            second_len = 0;
            truncated = 1'b0;
          end
          default: ;  // the spare action code leaves everything as it was
        endcase
      end
    end
    fail_count <= fails;
    pending <= expected_results.size();
    load_count <= loads;
    run_count <= runs;
    overflow_count <= truncations;
    longest <= widest;
  end

endmodule

>>> tb/edit_distance_engine_test.sv
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Loads string pairs into the engine and runs them, first a few hand-picked
// pairs, then random pairs of mostly short and a few full or overlong
// strings, some of them near copies of each other. Both channels idle at
// random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edit_distance_engine_test;

  import ede_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int LOADS_WANTED = 1700;
  localparam int DRAIN_CYCLES = 20000;
  localparam int TAIL_CYCLES  = 50;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int fail_count;
  int pending;
  int load_count;
  int run_count;
  int overflow_count;
  int longest;

  int sent_loads = 0;
  bit no_gaps = 1'b0;

  edit_distance_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  edit_distance_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .fail_count     (fail_count),
    .pending        (pending),
    .load_count     (load_count),
    .run_count      (run_count),
    .overflow_count (overflow_count),
    .longest        (longest)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Most pauses are short, a few are long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [SYMBOL_IN_W-1:0] pick_symbol(input bit narrow);
    if (narrow) return SYMBOL_IN_W'(8'h61 + $urandom_range(0, 3));
    return SYMBOL_IN_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 90) return $urandom_range(9, 24);
    if (r < 97) return $urandom_range(25, MAX_LEN - 1);
    return $urandom_range(MAX_LEN, MAX_LEN + 6);
  endfunction

  // A gap of zero keeps valid high straight into the next transfer, so valid
  // is only ever lowered when a pause really follows.
  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic [SYMBOL_IN_W-1:0] symbol);
    int gap;
    gap = no_gaps ? 0 : pick_pause();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{action: action, symbol: symbol};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (action != ACT_SPARE) sent_loads++;
  endtask

  // Loads both strings in a random interleaving, with the odd spare-code
  // transfer mixed in, and usually finishes with a run.
  task automatic load_pair(input int first_n, input int second_n,
                           input bit related, input bit narrow, input bit do_run);
    logic [SYMBOL_IN_W-1:0] a [$];
    logic [SYMBOL_IN_W-1:0] b [$];
    int ia;
    int ib;
    int k;
    int r;
    for (k = 0; k < first_n; k++) a.push_back(pick_symbol(narrow));
    if (related) begin
      for (k = 0; k < a.size(); k++) begin
        r = $urandom_range(0, 9);
        if (r == 1) begin
          b.push_back(pick_symbol(narrow));
          b.push_back(a[k]);
        end else if (r == 2) begin
          b.push_back(pick_symbol(narrow));
        end else if (r != 0) begin
          b.push_back(a[k]);
        end
      end
    end else begin
      for (k = 0; k < second_n; k++) b.push_back(pick_symbol(narrow));
    end
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if ($urandom_range(0, 29) == 0) send_item(ACT_SPARE, pick_symbol(1'b0));
      if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 0)) begin
        send_item(ACT_FIRST, a[ia]);
        ia++;
      end else begin
        send_item(ACT_SECOND, b[ib]);
        ib++;
      end
    end
    if (do_run) send_item(ACT_RUN, pick_symbol(1'b0));
  endtask

  initial begin
    int on_len;
    int off_len;
    while (rst) @(posedge clk);
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                           : $urandom_range(1, 20);
      result_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = pick_pause();
      if (off_len > 0) begin
        result_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin
    int seq;
    int drained;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked pairs: both strings empty, one string empty, equal single
    // symbols at the top of the range, two-symbol strings sharing one symbol,
    // and spare-code transfers between loads that must change nothing.
    send_item(ACT_RUN, 8'h00);
    send_item(ACT_FIRST, 8'h00);
    send_item(ACT_RUN, 8'h00);
    send_item(ACT_SECOND, 8'hFF);
    send_item(ACT_RUN, 8'h00);
    send_item(ACT_FIRST, 8'hFF);
    send_item(ACT_SECOND, 8'hFF);
    send_item(ACT_RUN, 8'h00);
    send_item(ACT_FIRST, 8'h00);
    send_item(ACT_FIRST, 8'hAA);
    send_item(ACT_SECOND, 8'hAA);
    send_item(ACT_SECOND, 8'h55);
    send_item(ACT_RUN, 8'hFF);
    send_item(ACT_SPARE, 8'h5A);
    send_item(ACT_FIRST, 8'h01);
    send_item(ACT_SPARE, 8'hFF);
    send_item(ACT_SECOND, 8'h80);
    send_item(ACT_RUN, 8'hFF);

    // The first random pairs fill both strings past their end, then pit an
    // empty string against a full one, then two near-identical full strings.
    seq = 0;
    while (sent_loads < LOADS_WANTED) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      case (seq)
        0: load_pair(MAX_LEN + 2, MAX_LEN + 1, 1'b0, 1'b0, 1'b1);
        1: load_pair(0, MAX_LEN, 1'b0, 1'b0, 1'b1);
        2: load_pair(MAX_LEN, 0, 1'b1, 1'b1, 1'b1);
        default: load_pair(pick_length(), pick_length(), $urandom_range(0, 9) < 4,
                           $urandom_range(0, 1) == 1, $urandom_range(0, 9) != 0);
      endcase
      seq++;
    end
    send_item(ACT_RUN, pick_symbol(1'b0));
    item_valid <= 1'b0;
    @(posedge clk);

    drained = 0;
    while (pending != 0 && drained < DRAIN_CYCLES) begin
      @(posedge clk);
      drained++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d symbol loads and %0d runs, %0d of them with truncated strings,",
             load_count, run_count, overflow_count);
    $display("with strings of up to %0d stored symbols.", longest);
    if (fail_count == 0 && pending == 0) begin
      $display("edit_distance_engine_test OK");
    end else begin
      $display("edit_distance_engine_test NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("edit_distance_engine_test NOT OK");
    $finish;
  end

endmodule
